// ===== src/pid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants of the PID controller step
// Register indexes, result status codes, the configuration bundle, the
// classified sample that travels from the front end to the back end, and a
// 32-bit saturation helper.
// ----------------------------------------------------------------------------
package pid_pkg;

	// Register indexes on the configuration write port.
	localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [2:0] REG_DERIV_SMOOTH = 3'd3;
	localparam logic [2:0] REG_INTEG_CLAMP = 3'd4;
	localparam logic [2:0] REG_INTEG_SEP   = 3'd5;
	localparam logic [2:0] REG_DEAD_BAND   = 3'd6;
	localparam logic [2:0] REG_SLEW_LIMIT  = 3'd7;

	// Result status codes; the front end tags each sample with the code it
	// will finish with.
	localparam logic [1:0] ST_COMPUTED = 2'd0;
	localparam logic [1:0] ST_HELD     = 2'd1;
	localparam logic [1:0] ST_DISABLED = 2'd2;

	// Default depth of the queue between front and back end.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [15:0] prop_gain;
		logic signed [15:0] integ_gain;
		logic signed [15:0] deriv_gain;
		logic        [15:0] deriv_smoothing;
		logic        [14:0] integ_clamp;
		logic        [15:0] integ_separation;
		logic        [15:0] dead_band;
		logic        [15:0] slew_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] measurement;
		logic signed [16:0] err;
		logic signed [15:0] out_min;
		logic signed [15:0] out_max;
		logic        [1:0]  kind;
		logic               on_meas;
		logic               integ_ok;
	} item_t;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -35'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== src/pid_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_front: sample classification
// Forms the control error and tags the sample as disabled, held by the dead
// band, or to be computed, and whether the integrator may run on it.
// ----------------------------------------------------------------------------
module pid_front (
	input  pid_pkg::cfg_t      cfg,
	input  logic signed [15:0] measurement,
	input  logic signed [15:0] setpoint,
	input  logic signed [15:0] out_min,
	input  logic signed [15:0] out_max,
	input  logic               enable,
	input  logic               deriv_on_measurement,
	output pid_pkg::item_t     item
);

	logic signed [16:0] err;
	logic        [16:0] err_mag;
	logic               held;

	assign err     = 17'(setpoint) - 17'(measurement);
	// Magnitude of -65536 is 65536, still representable unsigned in 17 bits.
	assign err_mag = err[16] ? 17'(-err) : 17'(err);
	assign held    = (cfg.dead_band != 16'd0) && (err_mag < {1'b0, cfg.dead_band});

	always_comb begin
		item.measurement = measurement;
		item.err         = err;
		item.out_min     = out_min;
		item.out_max     = out_max;
		item.on_meas     = deriv_on_measurement;
		item.integ_ok    = (cfg.integ_separation == 16'd0) ||
		                   (err_mag <= {1'b0, cfg.integ_separation});
		if (!enable) begin
			item.kind = pid_pkg::ST_DISABLED;
		end else if (held) begin
			item.kind = pid_pkg::ST_HELD;
		end else begin
			item.kind = pid_pkg::ST_COMPUTED;
		end
	end

endmodule

// ===== src/pid_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_queue: queue of classified samples
// A small circular buffer that lets the front end keep taking samples while
// the back end is busy.
// ----------------------------------------------------------------------------
module pid_queue #(
	parameter int DEPTH = pid_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pid_pkg::item_t wr_item,
	output logic           full,
	input  logic           rd_en,
	output pid_pkg::item_t rd_item,
	output logic           empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pid_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/pid_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_back: PID step sequencer
// Takes classified samples one at a time, runs the proportional, integral and
// filtered derivative products through one shared registered multiplier, and
// places the result in the output register.
// ----------------------------------------------------------------------------
module pid_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pid_pkg::cfg_t      cfg,
	input  pid_pkg::item_t     q_item,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic               pop,
	output logic               out_valid,
	output logic signed [15:0] drive,
	output logic        [1:0]  status
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_P     = 4'd1;
	localparam logic [3:0] S_I     = 4'd2;
	localparam logic [3:0] S_ACC   = 4'd3;
	localparam logic [3:0] S_CLAMP = 4'd4;
	localparam logic [3:0] S_F1    = 4'd5;
	localparam logic [3:0] S_F2    = 4'd6;
	localparam logic [3:0] S_SUM   = 4'd7;
	localparam logic [3:0] S_LIM   = 4'd8;
	localparam logic [3:0] S_SLEW  = 4'd9;

	localparam logic signed [50:0] FILT_HALF = 51'sd32768;
	localparam logic signed [17:0] FILT_ONE  = 18'sd65536;

	logic [3:0] state_q;

	// Controller state.
	logic signed [31:0] integ_accum_q;
	logic signed [31:0] deriv_term_q;
	logic signed [16:0] prev_error_q;
	logic signed [15:0] prev_meas_q;
	logic signed [15:0] prev_drive_q;

	// Working registers of the current sample.
	pid_pkg::item_t     cur_q;
	logic signed [49:0] prod_q;
	logic signed [32:0] p_q;
	logic signed [31:0] acc_tmp_q;
	logic signed [31:0] raw_q;
	logic signed [49:0] f1_q;
	logic signed [34:0] total_q;
	logic signed [15:0] lim_q;

	logic               out_valid_q;
	logic signed [15:0] drive_q;
	logic        [1:0]  status_q;

	logic signed [17:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [17:0] d_diff;
	logic signed [33:0] acc_sum;
	logic signed [50:0] filt;
	logic signed [50:0] filt_sh;
	logic signed [31:0] integ_lim;
	logic signed [31:0] acc_clamped;
	logic signed [34:0] quot;
	logic signed [34:0] lo_clamped;
	logic signed [34:0] hi_clamped;
	logic signed [17:0] slew_ext;
	logic signed [17:0] slew_lo;
	logic signed [17:0] slew_hi;
	logic signed [17:0] slewed;
	logic               start;

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign status    = status_q;

	assign start = (state_q == S_IDLE) && !q_empty && !out_valid_q;
	assign q_pop = start;

	// Derivative source; the negation for measurement mode is folded into the
	// order of the subtraction.
	assign d_diff = cur_q.on_meas ? (18'(prev_meas_q) - 18'(cur_q.measurement))
	                              : (18'(cur_q.err) - 18'(prev_error_q));

	always_comb begin
		unique case (state_q)
			S_P: begin
				mul_a = 18'(cfg.prop_gain);
				mul_b = 32'(cur_q.err);
			end
			S_I: begin
				mul_a = 18'(cfg.integ_gain);
				mul_b = 32'(cur_q.err);
			end
			S_ACC: begin
				mul_a = 18'(cfg.deriv_gain);
				mul_b = 32'(d_diff);
			end
			S_CLAMP: begin
				mul_a = $signed({2'b00, cfg.deriv_smoothing});
				mul_b = deriv_term_q;
			end
			S_F1: begin
				mul_a = FILT_ONE - $signed({2'b00, cfg.deriv_smoothing});
				mul_b = raw_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Integrator update and symmetric clamp.
	assign acc_sum   = 34'(integ_accum_q) + 34'($signed(prod_q[32:0]));
	assign integ_lim = $signed({9'd0, cfg.integ_clamp, 8'd0});

	always_comb begin
		acc_clamped = acc_tmp_q;
		if (cfg.integ_clamp != 15'd0) begin
			if (acc_tmp_q > integ_lim) begin
				acc_clamped = integ_lim;
			end
			if (acc_tmp_q < -integ_lim) begin
				acc_clamped = -integ_lim;
			end
		end
	end

	// Derivative filter, rounded half up by an arithmetic (floor) shift.
	assign filt    = 51'(f1_q) + 51'(prod_q) + FILT_HALF;
	assign filt_sh = filt >>> 16;

	// Division by 256 truncating toward zero, then the sample's limits.
	assign quot = (total_q + (total_q[34] ? 35'sd255 : 35'sd0)) >>> 8;

	always_comb begin
		lo_clamped = (quot < 35'(cur_q.out_min)) ? 35'(cur_q.out_min) : quot;
		hi_clamped = (lo_clamped > 35'(cur_q.out_max)) ? 35'(cur_q.out_max) : lo_clamped;
	end

	// Slew limit against the last computed drive.
	assign slew_ext = $signed({2'b00, cfg.slew_limit});
	assign slew_lo  = 18'(prev_drive_q) - slew_ext;
	assign slew_hi  = 18'(prev_drive_q) + slew_ext;

	always_comb begin
		slewed = 18'(lim_q);
		if (cfg.slew_limit != 16'd0) begin
			if (slewed < slew_lo) begin
				slewed = slew_lo;
			end
			if (slewed > slew_hi) begin
				slewed = slew_hi;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (start) begin
			cur_q <= q_item;
		end
		unique case (state_q)
			S_I: begin
				p_q <= prod_q[32:0];
			end
			S_ACC: begin
				acc_tmp_q <= cur_q.integ_ok ? pid_pkg::sat32(35'(acc_sum)) : integ_accum_q;
			end
			S_CLAMP: begin
				raw_q <= pid_pkg::sat32(35'($signed(prod_q[33:0])));
			end
			S_F1: begin
				f1_q <= prod_q;
			end
			S_SUM: begin
				total_q <= 35'(p_q) + 35'(integ_accum_q) + 35'(deriv_term_q);
			end
			S_LIM: begin
				lim_q <= hi_clamped[15:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			integ_accum_q <= '0;
			deriv_term_q  <= '0;
			prev_error_q  <= '0;
			prev_meas_q   <= '0;
			prev_drive_q  <= '0;
			out_valid_q   <= 1'b0;
			drive_q       <= '0;
			status_q      <= pid_pkg::ST_COMPUTED;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (q_item.kind == pid_pkg::ST_COMPUTED) begin
							state_q <= S_P;
						end else begin
							drive_q     <= prev_drive_q;
							status_q    <= q_item.kind;
							out_valid_q <= 1'b1;
						end
					end
				end
				S_P:   state_q <= S_I;
				S_I:   state_q <= S_ACC;
				S_ACC: state_q <= S_CLAMP;
				S_CLAMP: begin
					integ_accum_q <= acc_clamped;
					state_q       <= S_F1;
				end
				S_F1: state_q <= S_F2;
				S_F2: begin
					deriv_term_q <= pid_pkg::sat32(filt_sh[34:0]);
					state_q      <= S_SUM;
				end
				S_SUM: state_q <= S_LIM;
				S_LIM: state_q <= S_SLEW;
				S_SLEW: begin
					drive_q      <= slewed[15:0];
					status_q     <= pid_pkg::ST_COMPUTED;
					out_valid_q  <= 1'b1;
					prev_drive_q <= slewed[15:0];
					prev_error_q <= cur_q.err;
					prev_meas_q  <= cur_q.measurement;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/pid_controller_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_step: positional PID controller, one control sample a step
// Dead band, integral separation and clamp, filtered derivative on error or
// measurement, output clamp and slew limit.
// Usage. Samples enter through a queue-style port: a transaction takes place
// at a rising edge with push high and full low. Results leave the same way:
// while empty is low, drive and status show the oldest result, and it is
// taken at an edge with pop high. Gains and limits are written through
// wr_en, wr_index and wr_data while no sample is in flight.
// Sequence. A computed sample leaves the queue, then passes nine steps in which
// five products pass one after another through a single registered 18 x 32
// multiplier, followed by the filter, sum, limit and slew steps. A disabled or
// held sample goes from the queue straight to the output register and repeats
// the last drive. The next sample starts only in the cycle after the result is
// popped, so the back end works on one sample at a time. Stalls. While pop is
// held off, up to QUEUE_DEPTH samples wait in the queue, then full rises.
// Reset. arst_n clears the state, history, configuration and output registers;
// the queue storage and the working registers of a sample are not reset.
// ----------------------------------------------------------------------------
module pid_controller_step #(
	parameter int QUEUE_DEPTH = pid_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration writes.
	input  logic               wr_en,
	input  logic        [2:0]  wr_index,
	input  logic        [15:0] wr_data,
	// Sample input.
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] measurement,
	input  logic signed [15:0] setpoint,
	input  logic signed [15:0] out_min,
	input  logic signed [15:0] out_max,
	input  logic               enable,
	input  logic               deriv_on_measurement,
	// Result output.
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] drive,
	output logic        [1:0]  status
);

	pid_pkg::cfg_t  cfg_q;
	pid_pkg::item_t cls_item;
	pid_pkg::item_t q_item;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic           out_valid;

	// Configuration registers; all eight index codes name a register, so every
	// write lands in one of them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				pid_pkg::REG_PROP_GAIN:    cfg_q.prop_gain        <= wr_data;
				pid_pkg::REG_INTEG_GAIN:   cfg_q.integ_gain       <= wr_data;
				pid_pkg::REG_DERIV_GAIN:   cfg_q.deriv_gain       <= wr_data;
				pid_pkg::REG_DERIV_SMOOTH: cfg_q.deriv_smoothing  <= wr_data;
				pid_pkg::REG_INTEG_CLAMP:  cfg_q.integ_clamp      <= wr_data[14:0];
				pid_pkg::REG_INTEG_SEP:    cfg_q.integ_separation <= wr_data;
				pid_pkg::REG_DEAD_BAND:    cfg_q.dead_band        <= wr_data;
				pid_pkg::REG_SLEW_LIMIT:   cfg_q.slew_limit       <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: the sample is classified as it is pushed.
	pid_front u_front (
		.cfg                  (cfg_q),
		.measurement          (measurement),
		.setpoint             (setpoint),
		.out_min              (out_min),
		.out_max              (out_max),
		.enable               (enable),
		.deriv_on_measurement (deriv_on_measurement),
		.item                 (cls_item)
	);

	pid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !q_full),
		.wr_item (cls_item),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_item (q_item),
		.empty   (q_empty)
	);

	// Back end: the arithmetic sequence and the output register.
	pid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_item    (q_item),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.pop       (pop),
		.out_valid (out_valid),
		.drive     (drive),
		.status    (status)
	);

	assign full  = q_full;
	assign empty = !out_valid;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the PID controller step
// Control samples go in through the push/full queue port and results come
// back through empty/pop. A behavioral model of the controller predicts the
// drive and status of every accepted sample; each popped result is compared
// with the oldest prediction. Gains and limits are reloaded between phases
// while the block is idle. Directed samples come first, then random traffic.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 500000;

	// One control sample as it is presented on the input ports.
	typedef struct packed {
		logic signed [15:0] measurement;
		logic signed [15:0] setpoint;
		logic signed [15:0] out_min;
		logic signed [15:0] out_max;
		logic               enable;
		logic               deriv_on_measurement;
	} sample_t;

	// One result transaction.
	typedef struct packed {
		logic signed [15:0] drive;
		logic        [1:0]  status;
	} drive_result_t;

	// The full register set of the controller.
	typedef struct packed {
		logic signed [15:0] prop_gain;
		logic signed [15:0] integ_gain;
		logic signed [15:0] deriv_gain;
		logic        [15:0] deriv_smoothing;
		logic        [14:0] integ_clamp;
		logic        [15:0] integ_separation;
		logic        [15:0] dead_band;
		logic        [15:0] slew_limit;
	} gains_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic        [2:0]  wr_index = pid_pkg::REG_PROP_GAIN;
	logic        [15:0] wr_data = '0;
	logic               push = 1'b0;
	logic               full;
	logic signed [15:0] measurement = '0;
	logic signed [15:0] setpoint = '0;
	logic signed [15:0] out_min = '0;
	logic signed [15:0] out_max = '0;
	logic               enable = 1'b0;
	logic               deriv_on_measurement = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [15:0] drive;
	logic        [1:0]  status;

	// Model copy of the registers and of the controller history.
	gains_t             model_gains = '0;
	longint             integ_acc = 0;
	longint             deriv_filt = 0;
	logic signed [16:0] last_err = '0;
	logic signed [15:0] last_meas = '0;
	logic signed [15:0] last_drive = '0;

	// Predicted results, oldest first, waiting for their pop transaction.
	drive_result_t      pending_drives[$];

	int                 failures = 0;
	int                 cycle_count = 0;
	int                 sender_idle_pct = 18;
	int                 stall_pct = 18;
	logic signed [15:0] track_sp = '0;

	pid_controller_step u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.wr_en                (wr_en),
		.wr_index             (wr_index),
		.wr_data              (wr_data),
		.push                 (push),
		.full                 (full),
		.measurement          (measurement),
		.setpoint             (setpoint),
		.out_min              (out_min),
		.out_max              (out_max),
		.enable               (enable),
		.deriv_on_measurement (deriv_on_measurement),
		.empty                (empty),
		.pop                  (pop),
		.drive                (drive),
		.status               (status)
	);

	always #1 clk = ~clk;

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("pid_controller_step: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Controller model
	// ------------------------------------------------------------------

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Mirror a register write into the model.
	function automatic void apply_setting(input logic [2:0] idx, input logic [15:0] value);
		case (idx)
			pid_pkg::REG_PROP_GAIN:    model_gains.prop_gain = value;
			pid_pkg::REG_INTEG_GAIN:   model_gains.integ_gain = value;
			pid_pkg::REG_DERIV_GAIN:   model_gains.deriv_gain = value;
			pid_pkg::REG_DERIV_SMOOTH: model_gains.deriv_smoothing = value;
			pid_pkg::REG_INTEG_CLAMP:  model_gains.integ_clamp = value[14:0];
			pid_pkg::REG_INTEG_SEP:    model_gains.integ_separation = value;
			pid_pkg::REG_DEAD_BAND:    model_gains.dead_band = value;
			pid_pkg::REG_SLEW_LIMIT:   model_gains.slew_limit = value;
			default: ;
		endcase
	endfunction

	// One controller step: updates the model history and returns the result.
	// All arithmetic is done in 64 bits so that nothing wraps before the
	// explicit 32-bit saturation points.
	function automatic drive_result_t pid_predict_step(input sample_t s);
		drive_result_t r;
		longint        err, err_mag, prop, raw, total, bound, smooth, slew;
		r.drive = last_drive;
		if (!s.enable) begin
			r.status = pid_pkg::ST_DISABLED;
			return r;
		end
		err = longint'(s.setpoint) - longint'(s.measurement);
		err_mag = (err < 0) ? -err : err;
		// The dead band looks at the current error only and freezes everything.
		if (model_gains.dead_band != 0 && err_mag < longint'(model_gains.dead_band)) begin
			r.status = pid_pkg::ST_HELD;
			return r;
		end
		prop = longint'(model_gains.prop_gain) * err;

		// Integration pauses while the error is beyond the separation limit;
		// the clamp is applied on every computed step regardless.
		if (model_gains.integ_separation == 0 ||
				err_mag <= longint'(model_gains.integ_separation)) begin
			integ_acc = clip32(integ_acc + longint'(model_gains.integ_gain) * err);
		end
		if (model_gains.integ_clamp != 0) begin
			bound = longint'(model_gains.integ_clamp) * 256;
			if (integ_acc > bound) integ_acc = bound;
			if (integ_acc < -bound) integ_acc = -bound;
		end

		if (s.deriv_on_measurement) begin
			raw = -(longint'(model_gains.deriv_gain) *
				(longint'(s.measurement) - longint'(last_meas)));
		end else begin
			raw = longint'(model_gains.deriv_gain) * (err - longint'(last_err));
		end
		raw = clip32(raw);

		// First-order filter, Q0.16 weight on the old value, rounded half up.
		smooth = longint'(model_gains.deriv_smoothing);
		if (smooth != 0) begin
			deriv_filt = clip32((smooth * deriv_filt + (65536 - smooth) * raw + 32768) >>> 16);
		end else begin
			deriv_filt = raw;
		end

		// Drop the Q.8 fraction toward zero, then the lower limit before the
		// upper one, so inverted limits end on out_max.
		total = (prop + integ_acc + deriv_filt) / 256;
		if (total < longint'(s.out_min)) total = longint'(s.out_min);
		if (total > longint'(s.out_max)) total = longint'(s.out_max);
		slew = longint'(model_gains.slew_limit);
		if (slew != 0) begin
			if (total < longint'(last_drive) - slew) total = longint'(last_drive) - slew;
			if (total > longint'(last_drive) + slew) total = longint'(last_drive) + slew;
		end

		last_drive = total[15:0];
		last_err = err[16:0];
		last_meas = s.measurement;
		r.drive = total[15:0];
		r.status = pid_pkg::ST_COMPUTED;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random pop stalls and the compare against predictions
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		drive_result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_drives.size() == 0) begin
					$error("result with nothing predicted: drive %0d status %0d", drive, status);
					failures++;
				end else begin
					want = pending_drives.pop_front();
					if (drive !== want.drive) begin
						$error("drive: expected %0d, actual %0d", want.drive, drive);
						failures++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						failures++;
					end
				end
			end
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Write one register. wr_en is left high so that back-to-back writes do
	// not toggle it within one time step; load_settings lowers it at the end.
	task automatic put_reg(input logic [2:0] idx, input logic [15:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		apply_setting(idx, value);
	endtask

	// Reload the whole register set. Only called while nothing is in flight.
	task automatic load_settings(input gains_t g);
		put_reg(pid_pkg::REG_PROP_GAIN, g.prop_gain);
		put_reg(pid_pkg::REG_INTEG_GAIN, g.integ_gain);
		put_reg(pid_pkg::REG_DERIV_GAIN, g.deriv_gain);
		put_reg(pid_pkg::REG_DERIV_SMOOTH, g.deriv_smoothing);
		put_reg(pid_pkg::REG_INTEG_CLAMP, {1'b0, g.integ_clamp});
		put_reg(pid_pkg::REG_INTEG_SEP, g.integ_separation);
		put_reg(pid_pkg::REG_DEAD_BAND, g.dead_band);
		put_reg(pid_pkg::REG_SLEW_LIMIT, g.slew_limit);
		wr_en <= 1'b0;
	endtask

	function automatic gains_t make_gains(input int kp, input int ki, input int kd,
			input int smooth, input int clamp, input int sep, input int band, input int slew);
		gains_t g;
		g.prop_gain = 16'(kp);
		g.integ_gain = 16'(ki);
		g.deriv_gain = 16'(kd);
		g.deriv_smoothing = 16'(smooth);
		g.integ_clamp = 15'(clamp);
		g.integ_separation = 16'(sep);
		g.dead_band = 16'(band);
		g.slew_limit = 16'(slew);
		return g;
	endfunction

	function automatic sample_t make_sample(input int meas, input int sp, input int lo,
			input int hi, input bit en, input bit on_meas);
		sample_t s;
		s.measurement = 16'(meas);
		s.setpoint = 16'(sp);
		s.out_min = 16'(lo);
		s.out_max = 16'(hi);
		s.enable = en;
		s.deriv_on_measurement = on_meas;
		return s;
	endfunction

	// Present one sample and hold it until the push transaction completes.
	// push stays high afterwards; the next idle cycle or the drain lowers it.
	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < sender_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		measurement <= s.measurement;
		setpoint <= s.setpoint;
		out_min <= s.out_min;
		out_max <= s.out_max;
		enable <= s.enable;
		deriv_on_measurement <= s.deriv_on_measurement;
		@(posedge clk);
		while (full) @(posedge clk);
		pending_drives.push_back(pid_predict_step(s));
	endtask

	// Stop pushing and wait for every predicted result to be popped. Every
	// sample yields exactly one result, so an empty prediction list means the
	// block is idle and may be reconfigured.
	task automatic wait_drained();
		push <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
	endtask

	// Gains mostly within a few units of Q8.8 so that outputs stay off the
	// rails; now and then anything in the full range.
	function automatic logic [15:0] gain_pick(input int span);
		if ($urandom_range(7) == 0) return 16'($urandom);
		return 16'(int'($urandom_range(2 * span)) - span);
	endfunction

	function automatic gains_t random_gains();
		gains_t g;
		g.prop_gain = gain_pick(768);
		g.integ_gain = gain_pick(128);
		g.deriv_gain = gain_pick(512);
		g.deriv_smoothing = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
		g.integ_clamp = ($urandom_range(2) == 0) ? 15'd0 :
			($urandom_range(1) ? 15'($urandom_range(400)) : 15'($urandom));
		g.integ_separation = ($urandom_range(2) == 0) ? 16'd0 :
			($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4000)));
		g.dead_band = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(200));
		g.slew_limit = ($urandom_range(2) == 0) ? 16'd0 :
			($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2000)));
		return g;
	endfunction

	// Random samples follow a setpoint that moves now and then, with the
	// measurement mostly close to it, as in a loop that is actually tracking.
	// The rest is far off or completely random, with odd limits mixed in.
	function automatic sample_t random_sample();
		sample_t            s;
		int                 pick;
		logic signed [15:0] a, b;
		if ($urandom_range(15) == 0) track_sp = 16'($urandom);
		pick = $urandom_range(99);
		s.setpoint = ($urandom_range(19) == 0) ? 16'($urandom) : track_sp;
		if (pick < 50) begin
			s.measurement = 16'(int'(s.setpoint) + int'($urandom_range(600)) - 300);
		end else if (pick < 75) begin
			s.measurement = 16'(int'(s.setpoint) + int'($urandom_range(8000)) - 4000);
		end else begin
			s.measurement = 16'($urandom);
		end
		a = 16'($urandom);
		b = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 80) begin
			s.out_min = (a < b) ? a : b;
			s.out_max = (a < b) ? b : a;
		end else if (pick < 90) begin
			s.out_min = -16'sd32768;
			s.out_max = 16'sd32767;
		end else begin
			s.out_min = a;
			s.out_max = b;
		end
		s.enable = ($urandom_range(99) < 88);
		s.deriv_on_measurement = 1'($urandom_range(1));
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset every gain is zero: a computed step gives zero drive, and
	// a disabled step repeats the reset drive.
	task automatic test_after_reset();
		send_sample(make_sample(-32768, 32767, -32768, 32767, 1'b1, 1'b0));
		send_sample(make_sample(1234, -4321, -100, 100, 1'b0, 1'b1));
		wait_drained();
	endtask

	// Dead band, integral separation and clamp, the lock, both derivative
	// sources, inverted limits and the widest errors in both directions.
	task automatic test_special_cases();
		load_settings(make_gains(256, 64, 512, 32768, 50, 1000, 20, 0));
		send_sample(make_sample(90, 100, -32768, 32767, 1'b1, 1'b0));    // inside band
		send_sample(make_sample(80, 100, -32768, 32767, 1'b1, 1'b0));    // band edge
		send_sample(make_sample(0, 5000, -32768, 32767, 1'b1, 1'b0));    // beyond separation
		send_sample(make_sample(700, -700, -32768, 32767, 1'b0, 1'b0));  // locked
		send_sample(make_sample(1000, 5000, -32768, 32767, 1'b1, 1'b1)); // derivative on meas
		send_sample(make_sample(-200, 200, 300, -300, 1'b1, 1'b0));      // inverted limits
		send_sample(make_sample(-32768, 32767, -32768, 32767, 1'b1, 1'b0));
		send_sample(make_sample(32767, -32768, -32768, 32767, 1'b1, 1'b1));
		wait_drained();

		// Slew limiting with the heaviest filter, proportional and derivative gains only.
		load_settings(make_gains(1024, 0, 256, 65535, 0, 0, 0, 7));
		send_sample(make_sample(0, 20000, -32768, 32767, 1'b1, 1'b0));
		send_sample(make_sample(0, -20000, -32768, 32767, 1'b1, 1'b0));
		send_sample(make_sample(5000, -20000, -32768, 32767, 1'b1, 1'b1));
		send_sample(make_sample(0, 0, 10, 10, 1'b1, 1'b0));
		wait_drained();
	endtask

	// Full-scale gains and error swings push the raw derivative past the signed
	// 32-bit range and swing the integrator between large values and zero.
	task automatic test_saturation();
		load_settings(make_gains(32767, 32767, 32767, 1, 0, 0, 0, 0));
		send_sample(make_sample(-32768, 32767, -32768, 32767, 1'b1, 1'b0));
		send_sample(make_sample(32767, -32768, -32768, 32767, 1'b1, 1'b0));
		send_sample(make_sample(-32768, 32767, -32768, 32767, 1'b1, 1'b1));
		wait_drained();
		load_settings(make_gains(-32768, -32768, -32768, 1, 0, 0, 0, 0));
		send_sample(make_sample(32767, -32768, -32768, 32767, 1'b1, 1'b1));
		send_sample(make_sample(-32768, 32767, -32768, 32767, 1'b1, 1'b0));
		wait_drained();
	endtask

	task automatic run_phase(input gains_t g, input int count, input int idle_pct);
		sender_idle_pct = idle_pct;
		stall_pct = idle_pct;
		load_settings(g);
		repeat (count) send_sample(random_sample());
		wait_drained();
	endtask

	// Random traffic under a series of register settings: both extremes of
	// every register, all zero, then random sets. One phase runs with no
	// idling on either side so the block sees a long busy stretch.
	task automatic test_random_traffic();
		run_phase(make_gains(32767, 32767, 32767, 65535, 32767, 65535, 65535, 65535), 100, 18);
		run_phase(make_gains(-32768, -32768, -32768, 1, 1, 1, 1, 1), 100, 18);
		run_phase(make_gains(0, 0, 0, 0, 0, 0, 0, 0), 100, 18);
		for (int i = 0; i < 11; i++) begin
			run_phase(random_gains(), 150, (i == 5) ? 0 : 18);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_special_cases();
		test_saturation();
		test_random_traffic();

		// Everything has been popped; give the block a little longer to show
		// any stray result before the verdict.
		repeat (30) @(posedge clk);
		if (failures == 0) begin
			$display("pid_controller_step: match");
		end else begin
			$display("pid_controller_step: mismatch");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/pid_pkg.sv
src/pid_front.sv
src/pid_queue.sv
src/pid_back.sv
src/pid_controller_step.sv
tb/tb.sv
